### rtl/tihr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tihr_pkg
// shared types, constants and checksum helper for the header rewriter
// ----------------------------------------------------------------------------
package tihr_pkg;

	localparam int unsigned CfgIdxW   = 3;
	localparam int unsigned CfgDataW  = 48;
	localparam int unsigned QueueDepth = 4;

	// register indexes
	localparam logic [CfgIdxW-1:0] REG_MAC0  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_MAC1  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_VIRT0 = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_VIRT1 = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_WAN0  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_WAN1  = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_LAN   = 3'd6;

	localparam logic [15:0] ET_IPV4  = 16'h0800;
	localparam logic [15:0] ET_ARP   = 16'h0806;
	localparam logic [15:0] ARP_REQ  = 16'd1;
	localparam logic [15:0] ARP_REP  = 16'd2;
	localparam logic [7:0]  PROTO_ICMP = 8'd1;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;
	localparam logic [31:0] NET24    = 32'hffffff00;
	localparam logic [7:0]  ICMP_UNREACH = 8'd3;

	// rewrite action chosen by the front part
	typedef enum logic [3:0] {
		ACT_PASS,
		ACT_IP_SRC,      // lan->wan ip source to virtual
		ACT_IP_DST,      // wan->lan ip destination to wan
		ACT_SRC_COPY,    // arp source takes target
		ACT_SRC_SET,     // arp source takes value
		ACT_BOTH_SET,    // arp source and target take value
		ACT_DST_SET      // arp target takes value
	} act_t;

	// classified beat between front and back
	typedef struct packed {
		act_t        act;
		logic [31:0] val;        // new address value
		logic        tsum_upd;   // transport sum follows
		logic        udp;        // zero udp sum stays zero
		logic        icmp_inner; // embedded header rewrite
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] hsum;
		logic [15:0] tsum;
		logic [31:0] inner;
	} cls_t;

	typedef struct packed {
		logic [31:0] new_source;
		logic [31:0] new_target;
		logic [15:0] new_header_sum;
		logic [15:0] new_transport_sum;
		logic [31:0] new_inner_source;
		logic        was_modified;
	} res_t;

	// incremental ones'-complement update
	function automatic logic [15:0] csum_adjust(input logic [15:0] sum,
		input logic [31:0] oldv, input logic [31:0] newv);
		logic [31:0] inv;
		logic [18:0] acc;
		logic [16:0] f1;
		logic [15:0] f2;
		inv = ~oldv;
		acc = {3'b0, ~sum} + {3'b0, inv[31:16]} + {3'b0, inv[15:0]}
			+ {3'b0, newv[31:16]} + {3'b0, newv[15:0]};
		f1 = {1'b0, acc[15:0]} + {14'b0, acc[18:16]};
		f2 = f1[15:0] + {15'b0, f1[16]};
		return ~f2;
	endfunction

endpackage

### rtl/tihr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tihr_front
// holds configuration and skip flags, classifies each beat into an action
// ----------------------------------------------------------------------------
module tihr_front import tihr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                take,
	input  logic                direction,
	input  logic [47:0]         station_mac,
	input  logic [15:0]         ether_type,
	input  logic [15:0]         arp_opcode,
	input  logic [31:0]         addr_source,
	input  logic [31:0]         addr_target,
	input  logic [15:0]         ip_header_sum,
	input  logic [7:0]          ip_proto,
	input  logic [15:0]         fragment_field,
	input  logic [15:0]         transport_sum,
	input  logic [15:0]         icmp_kind,
	input  logic [31:0]         inner_source,
	output cls_t                cls
);

	logic [47:0] mac0_q, mac1_q;
	logic [31:0] virt0_q, virt1_q, wan0_q, wan1_q, lan_q;
	logic [1:0]  skip_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac0_q <= '0; mac1_q <= '0; virt0_q <= '0; virt1_q <= '0;
			wan0_q <= '0; wan1_q <= '0; lan_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAC0:  mac0_q  <= cfg_data;
				REG_MAC1:  mac1_q  <= cfg_data;
				REG_VIRT0: virt0_q <= cfg_data[31:0];
				REG_VIRT1: virt1_q <= cfg_data[31:0];
				REG_WAN0:  wan0_q  <= cfg_data[31:0];
				REG_WAN1:  wan1_q  <= cfg_data[31:0];
				REG_LAN:   lan_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	logic        m0, m1, cloned, id, frag_ok, lan_src;
	logic [31:0] virt_id, wan_id, gw;
	logic        skip_we, skip_val, id_eff;
	logic        tsum_ok;

	// classification
	always_comb begin
		m0 = station_mac == mac0_q;
		m1 = station_mac == mac1_q;
		cloned = m0 | m1;
		id = m1;
		frag_ok = fragment_field[7:0] == 8'h00;
		lan_src = (lan_q & NET24) == (addr_source & NET24);
		gw = (virt0_q & NET24) | 32'h1;
		tsum_ok = frag_ok && (ip_proto == PROTO_UDP || ip_proto == PROTO_TCP);
		id_eff = id;
		skip_we = 1'b0;
		skip_val = 1'b0;
		cls.act = ACT_PASS;
		cls.val = '0;
		cls.tsum_upd = 1'b0;
		cls.udp = ip_proto == PROTO_UDP;
		cls.icmp_inner = 1'b0;
		cls.src = addr_source;
		cls.dst = addr_target;
		cls.hsum = ip_header_sum;
		cls.tsum = transport_sum;
		cls.inner = inner_source;
		if (!cloned && direction == 1'b0 && ether_type == ET_ARP
			&& arp_opcode == ARP_REP) begin
			if (addr_target == virt0_q) id_eff = 1'b0;
			else if (addr_target == virt1_q) id_eff = 1'b1;
		end
		virt_id = id_eff ? virt1_q : virt0_q;
		wan_id = id_eff ? wan1_q : wan0_q;
		if (virt0_q != '0 || virt1_q != '0) begin
			if (direction == 1'b0) begin
				if (ether_type == ET_IPV4 && cloned) begin
					if (lan_src || addr_source == '0) begin
						skip_we = 1'b1; skip_val = 1'b1;
					end else begin
						cls.act = ACT_IP_SRC; cls.val = virt_id;
						cls.tsum_upd = tsum_ok;
						skip_we = 1'b1; skip_val = 1'b0;
					end
				end else if (ether_type == ET_ARP) begin
					if (arp_opcode == ARP_REQ && cloned) begin
						priority if (lan_src) begin
							skip_we = 1'b1; skip_val = 1'b1;
						end else if (addr_source == '0) begin
							cls.act = ACT_SRC_COPY;
						end else if (addr_source != addr_target
							&& addr_source != virt_id) begin
							cls.act = ACT_SRC_SET; cls.val = virt_id;
							skip_we = 1'b1; skip_val = 1'b0;
						end else if (addr_source == addr_target
							&& addr_source == wan_id) begin
							cls.act = ACT_BOTH_SET; cls.val = virt_id;
						end else begin
							cls.act = ACT_PASS;
						end
					end else if (arp_opcode == ARP_REP
						&& addr_source != addr_target) begin
						if (addr_source == wan_id && cloned) begin
							cls.act = ACT_SRC_SET; cls.val = virt_id;
						end else if (addr_source == gw && !cloned
							&& (addr_target == virt0_q || addr_target == virt1_q)) begin
							cls.act = ACT_DST_SET; cls.val = wan_id;
						end
					end
				end
			end else begin
				if (ether_type == ET_IPV4) begin
					if (!skip_q[id] && virt_id != '0 && cloned) begin
						cls.act = ACT_IP_DST; cls.val = wan_id;
						cls.tsum_upd = tsum_ok;
						cls.icmp_inner = ip_proto == PROTO_ICMP
							&& icmp_kind[15:8] == ICMP_UNREACH
							&& (icmp_kind[7:0] == 8'd3 || icmp_kind[7:0] == 8'd4);
					end
				end else if (ether_type == ET_ARP && skip_q != 2'b11) begin
					if (arp_opcode == ARP_REQ) begin
						priority if (addr_target == virt0_q && !skip_q[0]) begin
							cls.act = ACT_DST_SET; cls.val = wan0_q;
						end else if (addr_target == virt1_q && !skip_q[1]) begin
							cls.act = ACT_DST_SET; cls.val = wan1_q;
						end else if (addr_source == wan0_q || addr_source == wan1_q) begin
							cls.act = ACT_SRC_SET; cls.val = gw;
						end else begin
							cls.act = ACT_PASS;
						end
					end else if (arp_opcode == ARP_REP && addr_target == virt_id) begin
						cls.act = ACT_DST_SET; cls.val = wan_id;
					end
				end
			end
		end
	end

	// per-slot skip flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) skip_q <= 2'b11;
		else if (take && skip_we) skip_q[id_eff] <= skip_val;
	end

endmodule

### rtl/tihr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tihr_back
// applies the rewrite, updates checksums, one beat per cycle unless stalled
// ----------------------------------------------------------------------------
module tihr_back import tihr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cls_t in_cls,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	res_t r;
	logic [31:0] oldv;
	logic [15:0] hs_new, ts_new, ts_inner;

	// rewrite datapath
	always_comb begin
		oldv = in_cls.act == ACT_IP_SRC ? in_cls.src : in_cls.dst;
		hs_new = csum_adjust(in_cls.hsum, oldv, in_cls.val);
		ts_new = csum_adjust(in_cls.tsum, oldv, in_cls.val);
		ts_inner = csum_adjust(in_cls.tsum, in_cls.inner, in_cls.val);
		r.new_source = in_cls.src;
		r.new_target = in_cls.dst;
		r.new_header_sum = in_cls.hsum;
		r.new_transport_sum = in_cls.tsum;
		r.new_inner_source = in_cls.inner;
		r.was_modified = in_cls.act != ACT_PASS;
		unique case (in_cls.act)
			ACT_IP_SRC, ACT_IP_DST: begin
				if (in_cls.act == ACT_IP_SRC) r.new_source = in_cls.val;
				else r.new_target = in_cls.val;
				r.new_header_sum = hs_new;
				if (in_cls.tsum_upd && !(in_cls.udp && in_cls.tsum == '0))
					r.new_transport_sum = ts_new;
				else if (in_cls.icmp_inner) begin
					r.new_inner_source = in_cls.val;
					r.new_transport_sum = ts_inner;
				end
			end
			ACT_SRC_COPY: r.new_source = in_cls.dst;
			ACT_SRC_SET:  r.new_source = in_cls.val;
			ACT_BOTH_SET: begin
				r.new_source = in_cls.val;
				r.new_target = in_cls.val;
			end
			ACT_DST_SET:  r.new_target = in_cls.val;
			default: ;
		endcase
	end

	// output register
	assign in_ready = !out_valid || out_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (in_ready) out_valid <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) out_res <= r;
	end

endmodule

### rtl/tihr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tihr_queue
// short beat queue between classifier and rewrite stage
// ----------------------------------------------------------------------------
module tihr_queue import tihr_pkg::*; #(
	parameter int unsigned Depth = QueueDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cls_t push_data,
	output logic full,
	input  logic pop,
	output logic valid,
	output cls_t pop_data
);

	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

	cls_t           mem_q [Depth];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;

	assign full = cnt_q == (AW+1)'(Depth);
	assign valid = cnt_q != '0;
	assign pop_data = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= push_data;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			if (pop && valid)
				rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push && !full) - (AW+1)'(pop && valid);
		end
	end

endmodule

### rtl/twin_ip_header_rewriter_core.sv
`timescale 1ns / 1ps
// path: a pushed beat goes to the queue, then to the output (empty goes low)
// throughput: one beat per cycle while the output is not held, set by the
//   combinational classifier and registered rewrite behind a four-entry queue
// reset: asynchronous, clears queue pointers, output valid, configuration
//   registers and sets both slot skip flags
// ----------------------------------------------------------------------------
// twin_ip_header_rewriter_core
// top level: front classifier, beat queue, rewrite back end
// ----------------------------------------------------------------------------
module twin_ip_header_rewriter_core import tihr_pkg::*; #(
	parameter int unsigned Depth = QueueDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                push,
	output logic                full,
	input  logic                direction,
	input  logic [47:0]         station_mac,
	input  logic [15:0]         ether_type,
	input  logic [15:0]         arp_opcode,
	input  logic [31:0]         addr_source,
	input  logic [31:0]         addr_target,
	input  logic [15:0]         ip_header_sum,
	input  logic [7:0]          ip_proto,
	input  logic [15:0]         fragment_field,
	input  logic [15:0]         transport_sum,
	input  logic [15:0]         icmp_kind,
	input  logic [31:0]         inner_source,
	output logic                empty,
	input  logic                pop,
	output logic [31:0]         new_source,
	output logic [31:0]         new_target,
	output logic [15:0]         new_header_sum,
	output logic [15:0]         new_transport_sum,
	output logic [31:0]         new_inner_source,
	output logic                was_modified
);

	cls_t cls, q_data;
	logic q_valid, q_pop, out_valid;
	res_t res;

	tihr_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.take(push && !full), .direction, .station_mac, .ether_type,
		.arp_opcode, .addr_source, .addr_target, .ip_header_sum, .ip_proto,
		.fragment_field, .transport_sum, .icmp_kind, .inner_source, .cls
	);

	tihr_queue #(.Depth(Depth)) u_queue (
		.clk, .arst_n, .push, .push_data(cls), .full,
		.pop(q_pop), .valid(q_valid), .pop_data(q_data)
	);

	tihr_back u_back (
		.clk, .arst_n, .in_valid(q_valid), .in_ready(q_pop), .in_cls(q_data),
		.out_valid, .out_ready(pop), .out_res(res)
	);

	assign empty = !out_valid;
	assign new_source = res.new_source;
	assign new_target = res.new_target;
	assign new_header_sum = res.new_header_sum;
	assign new_transport_sum = res.new_transport_sum;
	assign new_inner_source = res.new_inner_source;
	assign was_modified = res.was_modified;

endmodule

### rtl/tihr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tihr_checker
// port-level checks on the queue handshake and pass-through results
// ----------------------------------------------------------------------------
module tihr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [31:0] new_source,
	input logic        was_modified
);

	// a held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(new_source))
		else $error("result changed while stalled");

	// no result shows in the cycle right after reset
	a_empty_after_reset: assert property (@(posedge clk)
		!arst_n |=> empty)
		else $error("result after reset");

	// a beat pushed into an idle block shows once through queue and output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && empty && $past(empty) && $past(!push) |=> ##1 !empty)
		else $error("beat lost");

	// modified flag is a single known bit whenever a result shows
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !$isunknown(was_modified))
		else $error("unknown modified flag");

endmodule

bind twin_ip_header_rewriter_core tihr_checker u_tihr_checker (
	.clk, .arst_n, .push, .full, .empty, .pop, .new_source, .was_modified
);
